FILE: hdl/rhht_pkg.sv
// Package for the Robin Hood hash table: sizes, codes, payload structs,
// HalfSipHash round function. No dependencies.
package rhht_pkg;
  localparam int TableSlots = 1024;
  localparam int SlotBits = $clog2(TableSlots);
  localparam int CountBits = SlotBits + 1;
  localparam int MaxKeyBytes = 8;
  localparam int LoadNum = 885;
  localparam int LoadShift = 10;
  localparam logic [CountBits-1:0] LoadLimit = CountBits'((TableSlots * LoadNum) >> LoadShift);
  localparam int EntryBits = 1 + 64 + 4 + 32 + CountBits + 32;

  localparam logic [1:0] OpFind = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StDup = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [10:0] occupancy;
  } res_t;

  // hashed job passed from front to back
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
    logic [3:0]  len;
    logic [31:0] hash;
    logic [31:0] value;
  } job_t;

  // slot entry as stored in RAM; disp is the probe distance from home
  typedef struct packed {
    logic                 used;
    logic [63:0]          key;
    logic [3:0]           len;
    logic [31:0]          hash;
    logic [CountBits-1:0] disp;
    logic [31:0]          payload;
  } entry_t;

  function automatic logic [127:0] sip_round(input logic [127:0] vin);
    logic [31:0] v0, v1, v2, v3;
    begin
      {v3, v2, v1, v0} = vin;
      v0 = v0 + v1; v1 = {v1[26:0], v1[31:27]}; v1 = v1 ^ v0; v0 = {v0[15:0], v0[31:16]};
      v2 = v2 + v3; v3 = {v3[23:0], v3[31:24]}; v3 = v3 ^ v2;
      v0 = v0 + v3; v3 = {v3[24:0], v3[31:25]}; v3 = v3 ^ v0;
      v2 = v2 + v1; v1 = {v1[18:0], v1[31:19]}; v1 = v1 ^ v2; v2 = {v2[15:0], v2[31:16]};
      return {v3, v2, v1, v0};
    end
  endfunction
endpackage

FILE: hdl/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: front end, job queue, back end.
// Uses rhht_pkg, rhht_front, rhht_queue, rhht_back.
//
// A command is taken when start is high and busy is low. Its key is hashed with
// HalfSipHash-2-4 under hash_seed, one round a cycle (6 to 10 rounds), and the
// job moves through a two-entry queue into the probe engine, which visits each
// slot on its single-port slot RAM with a read, then a check and write. A remove
// also examines slots in the backward shift, the stopping slot included. Hashing
// of the next command overlaps the probe of the previous one. Each result shows
// on done for exactly one cycle and cannot be held off. After reset a clearing
// pass empties the table; commands are queued meanwhile but not executed. Write
// hash_seed only while no command is pending.
module robin_hood_hash_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rhht_pkg::cmd_t cmd,
  output logic           busy,
  input  logic           seed_we,
  input  logic [63:0]    seed_wdata,
  output logic           done,
  output rhht_pkg::res_t result
);
  import rhht_pkg::*;

  logic [63:0] hash_seed;
  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  // hold the seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (seed_we) begin
      hash_seed <= seed_wdata;
    end
  end

  rhht_front u_front (
    .clk(clk), .rst(rst), .cmd_valid(start), .cmd(cmd), .cmd_busy(busy),
    .seed(hash_seed), .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  rhht_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_job(f_job), .in_ready(f_ready),
    .out_valid(q_valid), .out_job(q_job), .out_ready(q_ready)
  );

  rhht_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_valid), .job(q_job), .job_ready(q_ready),
    .res_strobe(done), .res(result)
  );
endmodule

FILE: hdl/rhht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module rhht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hdl/rhht_front.sv
// Front end: accepts commands, normalizes the key, runs HalfSipHash one round
// per cycle and pushes hashed jobs to the queue. Uses rhht_pkg.
module rhht_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  rhht_pkg::cmd_t   cmd,
  output logic             cmd_busy,
  input  logic [63:0]      seed,
  output logic             job_valid,
  output rhht_pkg::job_t   job,
  input  logic             job_ready
);
  import rhht_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state;
  logic [127:0] v;
  logic [3:0] step;      // total rounds to run
  logic [3:0] round_cnt;
  job_t cur;

  logic [3:0] len_n;
  logic [63:0] key_n;
  logic [127:0] v_r;
  logic [31:0] m0, m1, mb;
  logic [1:0] full_w;
  // round schedule: absorb blocks of 2 rounds, then 4 finals
  logic [3:0] absorb_rounds;

  always_comb begin
    len_n = cmd.key_length;
    if (len_n == 4'd0) len_n = 4'd1;
    if (len_n > 4'(MaxKeyBytes)) len_n = 4'(MaxKeyBytes);
    key_n = cmd.key_bytes;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= len_n) key_n[b*8 +: 8] = 8'd0;
    end
  end

  always_comb begin
    full_w = cur.len[3:2] > 2'd2 ? 2'd2 : cur.len[3:2];
    absorb_rounds = {1'b0, full_w, 1'b0} + 4'd2;
    m0 = cur.key[31:0];
    m1 = cur.key[63:32];
    mb = {cur.len, 24'd0};
    if (full_w == 2'd0) mb = mb | m0;
    else if (full_w == 2'd1) mb = mb | m1;
  end

  // message word of the block that the current round pair belongs to
  function automatic logic [31:0] blk_msg(input logic [3:0] r, input logic [1:0] f,
                                          input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    logic [1:0] blk;
    begin
      blk = r[2:1];
      if (blk == 2'd0 && f != 2'd0) return a;
      if (blk == 2'd1 && f == 2'd2) return b;
      return c;
    end
  endfunction

  logic [31:0] m_cur;
  logic [127:0] v_in;
  logic [127:0] v_out;

  always_comb begin
    m_cur = blk_msg(round_cnt, full_w, m0, m1, mb);
    v_in = v;
    // start of an absorb block: xor the word into v3
    if (round_cnt < absorb_rounds && !round_cnt[0]) begin
      v_in[127:96] = v[127:96] ^ m_cur;
    end
    // start of finalization
    if (round_cnt == absorb_rounds) begin
      v_in[95:64] = v[95:64] ^ 32'h0000_00ff;
    end
    v_r = sip_round(v_in);
    v_out = v_r;
    // end of an absorb block: xor the word into v0
    if (round_cnt < absorb_rounds && round_cnt[0]) begin
      v_out[31:0] = v_r[31:0] ^ m_cur;
    end
  end

  assign step = absorb_rounds + 4'd4;
  assign cmd_busy = (state != F_IDLE);
  assign job_valid = (state == F_PUSH);
  assign job = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (cmd_valid) begin
            cur.operation <= cmd.operation;
            cur.key <= key_n;
            cur.len <= len_n;
            cur.value <= cmd.value;
            v <= {seed[63:32] ^ 32'h7465_6462, seed[31:0] ^ 32'h6c79_6765,
                  seed[63:32], seed[31:0]};
            round_cnt <= 4'd0;
            state <= F_HASH;
          end
        end
        F_HASH: begin
          v <= v_out;
          round_cnt <= round_cnt + 4'd1;
          if (round_cnt == step - 4'd1) begin
            cur.hash <= v_r[63:32] ^ v_r[127:96];
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) job_valid |-> cmd_busy)
    else $error("job offered while front idle");
  assert property (@(posedge clk) disable iff (rst) (state == F_HASH) |-> round_cnt < step)
    else $error("hash round count overrun");
  assert property (@(posedge clk) disable iff (rst)
                   (state == F_PUSH && !job_ready) |=> (state == F_PUSH && $stable(cur)))
    else $error("job dropped while queue full");
endmodule

FILE: hdl/rhht_queue.sv
// Two-entry job queue between front and back end.
// Uses rhht_pkg.
module rhht_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rhht_pkg::job_t in_job,
  output logic           in_ready,
  output logic           out_valid,
  output rhht_pkg::job_t out_job,
  input  logic           out_ready
);
  import rhht_pkg::*;

  job_t buf_q [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job = buf_q[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) buf_q[wptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (out_valid && out_ready) rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd0 && in_valid) |=> count == 2'd1)
    else $error("push into empty queue lost");
  assert property (@(posedge clk) disable iff (rst)
                   (wptr == rptr) |-> (count == 2'd0 || count == 2'd2))
    else $error("queue pointers disagree with count");
endmodule

FILE: hdl/rhht_back.sv
// Back end: clearing pass, then find/insert/remove with linear probing over the
// slot RAM, one slot read or write a cycle. Uses rhht_pkg and rhht_ram.
module rhht_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  rhht_pkg::job_t job,
  output logic           job_ready,
  output logic           res_strobe,
  output rhht_pkg::res_t res
);
  import rhht_pkg::*;

  typedef enum logic [7:0] {
    B_CLEAR = 8'b0000_0001,
    B_IDLE  = 8'b0000_0010,
    B_RD    = 8'b0000_0100,
    B_CHK   = 8'b0000_1000,
    B_SRD   = 8'b0001_0000,
    B_SCHK  = 8'b0010_0000,
    B_DONE  = 8'b0100_0000
  } bstate_t;

  bstate_t state;
  logic [SlotBits-1:0] addr, clr_addr;
  logic [CountBits-1:0] count, n;
  job_t j;
  entry_t carry;        // entry being carried on insert
  logic [1:0] st;
  logic [31:0] rv;

  logic ram_we;
  logic [SlotBits-1:0] ram_addr;
  entry_t ram_wdata, rd;
  logic [EntryBits-1:0] rd_bits;

  assign rd = entry_t'(rd_bits);

  rhht_ram #(.Width(EntryBits), .Depth(TableSlots)) u_slots (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(EntryBits'(ram_wdata)), .rdata(rd_bits)
  );

  logic match;
  assign match = rd.used && rd.hash == carry.hash && rd.len == carry.len && rd.key == carry.key;

  always_comb begin
    ram_we = 1'b0;
    ram_addr = addr;
    ram_wdata = '0;
    case (state)
      B_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_addr;
      end
      B_CHK: begin
        if (j.operation == OpInsert && (!rd.used || (!match && carry.disp > rd.disp))) begin
          ram_we = 1'b1;
          ram_wdata = carry;
        end
      end
      B_SCHK: begin
        // pull the next entry back one slot, or empty this slot
        ram_we = 1'b1;
        ram_addr = addr - SlotBits'(1);
        if (rd.used && rd.disp != '0) begin
          ram_wdata = rd;
          ram_wdata.disp = rd.disp - CountBits'(1);
        end
      end
      default: ;
    endcase
  end

  assign job_ready = (state == B_IDLE);
  assign res_strobe = (state == B_DONE);
  assign res = '{status: st, result_value: rv, occupancy: 11'(count)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr_addr <= '0;
      count <= '0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + SlotBits'(1);
          if (clr_addr == SlotBits'(TableSlots - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (job_valid) begin
            j <= job;
            carry <= '{used: 1'b1, key: job.key, len: job.len, hash: job.hash,
                       disp: '0, payload: job.value};
            addr <= job.hash[SlotBits-1:0];
            n <= '0;
            rv <= '0;
            if (job.operation == OpInsert && count > LoadLimit) begin
              st <= StFull;
              state <= B_DONE;
            end else if (job.operation == OpInsert) begin
              st <= StOk;
              state <= B_RD;
            end else if (job.operation == OpFind || job.operation == OpRemove) begin
              st <= StNotFound;
              state <= B_RD;
            end else begin
              st <= StNotFound;
              state <= B_DONE;
            end
          end
        end
        B_RD: state <= B_CHK;
        B_CHK: begin
          if (j.operation == OpInsert) begin
            if (!rd.used) begin
              count <= count + CountBits'(1);
              state <= B_DONE;
            end else if (match) begin
              st <= StDup;
              rv <= rd.payload;
              state <= B_DONE;
            end else begin
              if (carry.disp > rd.disp) begin
                carry <= '{used: rd.used, key: rd.key, len: rd.len, hash: rd.hash,
                           disp: rd.disp + CountBits'(1), payload: rd.payload};
              end else begin
                carry.disp <= carry.disp + CountBits'(1);
              end
              addr <= addr + SlotBits'(1);
              n <= n + CountBits'(1);
              if (n == CountBits'(TableSlots - 1)) state <= B_DONE;
              else state <= B_RD;
            end
          end else begin
            if (!rd.used || carry.disp > rd.disp) begin
              state <= B_DONE;
            end else if (match) begin
              st <= StOk;
              rv <= rd.payload;
              if (j.operation == OpRemove) begin
                count <= count - CountBits'(1);
                addr <= addr + SlotBits'(1);
                n <= '0;
                state <= B_SRD;
              end else begin
                state <= B_DONE;
              end
            end else begin
              carry.disp <= carry.disp + CountBits'(1);
              addr <= addr + SlotBits'(1);
              n <= n + CountBits'(1);
              if (n == CountBits'(TableSlots - 1)) state <= B_DONE;
              else state <= B_RD;
            end
          end
        end
        B_SRD: state <= B_SCHK;
        B_SCHK: begin
          n <= n + CountBits'(1);
          if (!rd.used || rd.disp == '0 || n == CountBits'(TableSlots - 1)) begin
            state <= B_DONE;
          end else begin
            addr <= addr + SlotBits'(1);
            state <= B_SRD;
          end
        end
        B_DONE: state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CountBits'(TableSlots))
    else $error("entry count above table size");
  assert property (@(posedge clk) disable iff (rst) res_strobe |=> !res_strobe)
    else $error("result strobe held for two cycles");
  assert property (@(posedge clk) disable iff (rst)
                   (res_strobe && res.status == StFull) |-> $stable(count))
    else $error("full insert changed the count");
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the Robin Hood hash table: drives find, insert,
// remove and unused-code commands, predicts each result with a software map model.
// Depends on rhht_pkg and robin_hood_hash_table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rhht_pkg::*;

  localparam int Slots = TableSlots;
  localparam int IdleLimit = 20000;

  // Software model of the map plus the queue of pending expected results.
  class map_scoreboard;
    logic [63:0] seed;
    logic [63:0] s_key[Slots];
    logic [3:0] s_len[Slots];
    logic [31:0] s_hash[Slots];
    int unsigned s_dist[Slots];
    logic [31:0] s_pay[Slots];
    int unsigned entries;
    res_t pending[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      seed = '0;
      entries = 0;
      mismatches = 0;
      checked = 0;
      foreach (s_len[i]) s_len[i] = '0;
    endfunction

    function automatic logic [31:0] rotl(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function automatic void mix(ref logic [31:0] v[4]);
      v[0] += v[1]; v[1] = rotl(v[1], 5); v[1] ^= v[0]; v[0] = rotl(v[0], 16);
      v[2] += v[3]; v[3] = rotl(v[3], 8); v[3] ^= v[2];
      v[0] += v[3]; v[3] = rotl(v[3], 7); v[3] ^= v[0];
      v[2] += v[1]; v[1] = rotl(v[1], 13); v[1] ^= v[2]; v[2] = rotl(v[2], 16);
    endfunction

    function automatic void absorb(ref logic [31:0] v[4], input logic [31:0] m);
      v[3] ^= m;
      mix(v);
      mix(v);
      v[0] ^= m;
    endfunction

    function automatic logic [31:0] half_sip(logic [63:0] key, int len);
      logic [31:0] v[4];
      logic [31:0] w[2];
      logic [31:0] tail;
      int full;
      full = len / 4;
      w[0] = key[31:0];
      w[1] = key[63:32];
      v[0] = seed[31:0];
      v[1] = seed[63:32];
      v[2] = 32'h6c796765 ^ seed[31:0];
      v[3] = 32'h74656462 ^ seed[63:32];
      for (int i = 0; i < full; i++) absorb(v, w[i]);
      tail = 32'(len) << 24;
      if (full < 2) tail |= w[full];
      absorb(v, tail);
      v[2] ^= 32'hFF;
      for (int i = 0; i < 4; i++) mix(v);
      return v[1] ^ v[3];
    endfunction

    function automatic int find_slot(logic [63:0] key, int len, logic [31:0] h);
      int i;
      i = h % Slots;
      for (int d = 0; d < Slots; d++) begin
        if (s_len[i] == 0 || d > s_dist[i]) return Slots;
        if (s_hash[i] == h && s_len[i] == len && s_key[i] == key) return i;
        i = (i + 1) % Slots;
      end
      return Slots;
    endfunction

    // Note an accepted command: update the map and queue its result.
    function automatic void note_command(cmd_t c);
      res_t r;
      int len, i, j;
      logic [63:0] key, ck, tk;
      logic [31:0] h, chh, cp, th, tp;
      logic [3:0] cl, tl;
      int unsigned cd, td;
      r.status = StNotFound;
      r.result_value = '0;
      len = c.key_length;
      if (len == 0) len = 1;
      if (len > MaxKeyBytes) len = MaxKeyBytes;
      key = c.key_bytes;
      if (len < 8) key &= (64'd1 << (8 * len)) - 1;
      h = half_sip(key, len);
      case (c.operation)
        OpFind: begin
          i = find_slot(key, len, h);
          if (i < Slots) begin
            r.status = StOk;
            r.result_value = s_pay[i];
          end
        end
        OpInsert: begin
          if (entries > LoadLimit) begin
            r.status = StFull;
          end else begin
            ck = key; cl = 4'(len); chh = h; cd = 0; cp = c.value;
            i = h % Slots;
            r.status = StOk;
            for (int n = 0; n < Slots; n++) begin
              if (s_len[i] == 0) begin
                s_key[i] = ck; s_len[i] = cl; s_hash[i] = chh;
                s_dist[i] = cd; s_pay[i] = cp;
                entries++;
                break;
              end
              if (s_hash[i] == chh && s_len[i] == cl && s_key[i] == ck) begin
                r.status = StDup;
                r.result_value = s_pay[i];
                break;
              end
              // swap with the richer resident and carry it onward
              if (cd > s_dist[i]) begin
                tk = s_key[i]; tl = s_len[i]; th = s_hash[i];
                td = s_dist[i]; tp = s_pay[i];
                s_key[i] = ck; s_len[i] = cl; s_hash[i] = chh;
                s_dist[i] = cd; s_pay[i] = cp;
                ck = tk; cl = tl; chh = th; cd = td; cp = tp;
              end
              cd++;
              i = (i + 1) % Slots;
            end
          end
        end
        OpRemove: begin
          i = find_slot(key, len, h);
          if (i < Slots) begin
            r.status = StOk;
            r.result_value = s_pay[i];
            entries--;
            // backward shift until an empty slot or an entry at its home
            for (int n = 0; n < Slots; n++) begin
              s_len[i] = '0;
              j = (i + 1) % Slots;
              if (s_len[j] == 0 || s_dist[j] == 0) break;
              s_key[i] = s_key[j]; s_len[i] = s_len[j]; s_hash[i] = s_hash[j];
              s_dist[i] = s_dist[j] - 1; s_pay[i] = s_pay[j];
              i = j;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = 11'(entries);
      pending.push_back(r);
    endfunction

    function automatic void check_result(res_t got);
      res_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p at %0t", got, $time);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.result_value !== want.result_value ||
          got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected st=%0d val=%h occ=%0d, got st=%0d val=%h occ=%0d",
                   $time, want.status, want.result_value, want.occupancy,
                   got.status, got.result_value, got.occupancy);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic seed_we;
  logic [63:0] seed_wdata;
  logic done;
  res_t result;

  map_scoreboard board;
  int unsigned idle_cycles;
  int unsigned transfers;
  logic calm;
  logic [63:0] key_pool[64];
  int key_pool_len[64];

  robin_hood_hash_table u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .seed_we(seed_we),
    .seed_wdata(seed_wdata),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Check each result transfer and watch for a stuck block.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result(result);
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("watchdog expired with %0d results outstanding", board.pending.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one command and hold it until the transfer happens, then drop
  // start and wait so that the next command starts on a later edge.
  task automatic send_command(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                              logic [31:0] val);
    cmd_t c;
    c.operation = op;
    c.key_bytes = key;
    c.key_length = len;
    c.value = val;
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(posedge clk);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    board.note_command(c);
    transfers++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_seed(logic [63:0] s);
    seed_we <= 1'b1;
    seed_wdata <= s;
    @(posedge clk);
    seed_we <= 1'b0;
    board.seed = s;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly reuse a small key pool so that finds, duplicates and removes hit.
  task automatic random_phase(int count, int fill_bias);
    int k, pick;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < fill_bias) op = OpInsert;
      else if (pick < fill_bias + (100 - fill_bias) / 2) op = OpFind;
      else if (pick < 98) op = OpRemove;
      else op = 2'd3;
      if ($urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, 63);
        send_command(op, key_pool[k] | (rand64() << (8 * key_pool_len[k]) &
                     {64{key_pool_len[k] < 8}}), 4'(key_pool_len[k]), $urandom());
      end else begin
        send_command(op, rand64(), 4'($urandom_range(0, 15)), $urandom());
      end
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    seed_we = 1'b0;
    seed_wdata = '0;
    idle_cycles = 0;
    transfers = 0;
    calm = 1'b0;
    for (int i = 0; i < 64; i++) begin
      key_pool_len[i] = $urandom_range(1, 8);
      key_pool[i] = rand64();
      if (key_pool_len[i] < 8) key_pool[i] &= (64'd1 << (8 * key_pool_len[i])) - 1;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every operation, odd lengths and codes
    load_seed(64'h0);
    send_command(OpFind, 64'h0, 4'd1, 32'h1);
    send_command(OpInsert, 64'h0, 4'd1, 32'hFFFF_FFFF);
    send_command(OpInsert, 64'h0, 4'd1, 32'h5);
    send_command(OpFind, 64'hFF00, 4'd1, 32'h0);
    send_command(OpInsert, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_command(OpFind, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0);
    send_command(OpInsert, 64'h42, 4'd0, 32'h1234);
    send_command(OpFind, 64'h42, 4'd1, 32'h0);
    send_command(OpInsert, 64'h1122_3344, 4'd4, 32'hA5A5_A5A5);
    send_command(OpFind, 64'hFF11_2233_44, 4'd4, 32'h0);
    send_command(2'd3, 64'h42, 4'd1, 32'h9);
    send_command(OpRemove, 64'h42, 4'd1, 32'h0);
    send_command(OpRemove, 64'h42, 4'd1, 32'h0);
    send_command(OpFind, 64'h42, 4'd1, 32'h0);
    send_command(OpRemove, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    drain();

    load_seed(64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(300, 45);
    drain();
    load_seed(rand64());
    // fill past the load mark to reach the full status, then drain down
    for (int n = 0; n < 950; n++) send_command(OpInsert, rand64(), 4'($urandom_range(1, 8)),
                                                $urandom());
    random_phase(200, 20);
    drain();
    load_seed(64'h0123_4567_89AB_CDEF);
    calm = 1'b1;
    random_phase(300, 30);
    drain();

    $display("covered %0d command transfers, %0d results checked, peak fill past load mark",
             transfers, board.checked);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
